// ----- sv/srtf_pkg.sv -----
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared types and constants of the system call rule table filter: command
// and action codes, sequencer states and the layout of one stored rule.
// ----------------------------------------------------------------------------
package srtf_pkg;

    localparam int KEY_W    = 10;
    localparam int PID_W    = 6;
    localparam int NEWP_W   = 5;
    localparam int COUNT_W  = 32;

    typedef enum logic [1:0] {
        CMD_CREATE   = 2'd0,
        CMD_ADD      = 2'd1,
        CMD_ACTIVATE = 2'd2,
        CMD_CHECK    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ACT_ALLOW = 2'd0,
        ACT_DENY  = 2'd1,
        ACT_KILL  = 2'd2,
        ACT_TRACE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_META,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        t_action          kind;
    } t_rule_ent;

endpackage

// ----- sv/srtf_rule_store.sv -----
// ----------------------------------------------------------------------------
// srtf_rule_store
// Rule memory: one write port and one read port, read data registered.
// Entries hold a call number and its action.
// ----------------------------------------------------------------------------
module srtf_rule_store
    import srtf_pkg::*;
#(
    parameter int AW = 13
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  t_rule_ent       i_wr_data,
    input  logic [AW-1:0]   i_rd_addr,
    output t_rule_ent       o_rd_data
);

    t_rule_ent r_mem [2**AW];
    t_rule_ent r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/syscall_rule_table_filter.sv -----
// ----------------------------------------------------------------------------
// syscall_rule_table_filter
// First-match system call filter. Profiles hold ordered rule lists kept in a
// rule memory; per-profile active flag and rule count live in a small
// profile memory. A check scans the profile's rules one per cycle.
//
//   channel   direction  handshake           payload
//   command   in         i_valid / o_ready   i_command, i_profile_id,
//                                            i_call_number, i_rule_action
//   result    out        o_valid / i_ready   o_status, o_new_profile,
//                                            o_permitted, o_rule_hit,
//                                            o_hit_action, o_violation_count,
//                                            o_allowed_count
//
// create, add and activate pass through S_META and S_DONE before the next accept;
// a check also passes through S_SCAN, reading one rule per cycle through the single
// rule memory read port up to and including the first match (all rules when none
// matches, none for an invalid, inactive or empty profile).
// Reset clears the profile count, both counters and the result valid flag.
// A stalled result holds the next transaction in its last cycle until taken.
// ----------------------------------------------------------------------------
module syscall_rule_table_filter
    import srtf_pkg::*;
#(
    parameter int PROFILE_SLOTS     = 32,
    parameter int RULES_PER_PROFILE = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_command,
    input  logic [PID_W-1:0]    i_profile_id,
    input  logic [KEY_W-1:0]    i_call_number,
    input  logic [1:0]          i_rule_action,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_status,
    output logic [NEWP_W-1:0]   o_new_profile,
    output logic                o_permitted,
    output logic                o_rule_hit,
    output logic [1:0]          o_hit_action,
    output logic [COUNT_W-1:0]  o_violation_count,
    output logic [COUNT_W-1:0]  o_allowed_count
);

    localparam int PW  = (PROFILE_SLOTS > 1) ? $clog2(PROFILE_SLOTS) : 1;
    localparam int UW  = $clog2(PROFILE_SLOTS + 1);
    localparam int RW  = (RULES_PER_PROFILE > 1) ? $clog2(RULES_PER_PROFILE) : 1;
    localparam int CW  = $clog2(RULES_PER_PROFILE + 1);
    localparam int AW  = PW + RW;
    localparam int VW  = UW + PID_W;

    typedef struct packed {
        logic          active;
        logic [CW-1:0] used;
    } t_meta;

    // sequencer
    t_state              r_state, n_state;

    // command in flight
    t_cmd                r_cmd, n_cmd;
    logic [PID_W-1:0]    r_pid, n_pid;
    logic [KEY_W-1:0]    r_num, n_num;
    t_action             r_act, n_act;

    // result being built
    logic                r_status, n_status;
    logic [NEWP_W-1:0]   r_newp, n_newp;
    logic                r_perm, n_perm;
    logic                r_hit, n_hit;
    t_action             r_hact, n_hact;

    // scan
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [RW-1:0]       r_idx, n_idx;

    // global state
    logic [UW-1:0]       r_prof_used, n_prof_used;
    logic [COUNT_W-1:0]  r_viol, n_viol;
    logic [COUNT_W-1:0]  r_allow, n_allow;

    // result register
    logic                r_out_valid;
    logic                r_out_status;
    logic [NEWP_W-1:0]   r_out_newp;
    logic                r_out_perm;
    logic                r_out_hit;
    t_action             r_out_hact;
    logic [COUNT_W-1:0]  r_out_viol;
    logic [COUNT_W-1:0]  r_out_allow;

    // profile memory
    t_meta               r_meta [2**PW];
    t_meta               r_meta_rd;
    logic                w_meta_we;
    logic [PW-1:0]       w_meta_waddr;
    t_meta               w_meta_wdata;

    // rule memory ports
    logic                w_rule_we;
    logic [AW-1:0]       w_rule_waddr;
    t_rule_ent           w_rule_wdata;
    logic [AW-1:0]       w_rule_raddr;
    t_rule_ent           w_rule_rd;

    // decisions
    logic                w_accept;
    logic                w_pid_ok;
    logic                w_prof_full;
    logic                w_rules_full;
    logic                w_scan_go;
    logic                w_match;
    logic                w_scan_last;
    logic                w_out_load;
    logic [PW-1:0]       w_pidx;

    assign o_ready      = (r_state == S_IDLE);
    assign w_accept     = i_valid && o_ready;
    assign w_pidx       = r_pid[PW-1:0];
    assign w_pid_ok     = VW'(r_pid) < VW'(r_prof_used);
    assign w_prof_full  = r_prof_used >= UW'(PROFILE_SLOTS);
    assign w_rules_full = r_meta_rd.used >= CW'(RULES_PER_PROFILE);
    assign w_scan_go    = w_pid_ok && r_meta_rd.active && (r_meta_rd.used != '0);
    assign w_match      = (w_rule_rd.key == r_num);
    assign w_scan_last  = (CW'(r_idx) + CW'(1)) == r_cnt;
    assign w_out_load   = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // profile memory: read address follows the command port, so the entry
    // of an accepted transaction is ready in S_META
    always_ff @(posedge i_clk) begin
        if (w_meta_we) begin
            r_meta[w_meta_waddr] <= w_meta_wdata;
        end
        r_meta_rd <= r_meta[i_profile_id[PW-1:0]];
    end

    srtf_rule_store #(
        .AW (AW)
    ) u_rule_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_rule_we),
        .i_wr_addr (w_rule_waddr),
        .i_wr_data (w_rule_wdata),
        .i_rd_addr (w_rule_raddr),
        .o_rd_data (w_rule_rd)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_META;
                end
            end
            S_META: begin
                if (r_cmd == CMD_CHECK && w_scan_go) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (w_match || w_scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_cmd        = r_cmd;
        n_pid        = r_pid;
        n_num        = r_num;
        n_act        = r_act;
        n_status     = r_status;
        n_newp       = r_newp;
        n_perm       = r_perm;
        n_hit        = r_hit;
        n_hact       = r_hact;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_prof_used  = r_prof_used;
        n_viol       = r_viol;
        n_allow      = r_allow;
        w_meta_we    = 1'b0;
        w_meta_waddr = w_pidx;
        w_meta_wdata = r_meta_rd;
        w_rule_we    = 1'b0;
        w_rule_waddr = {w_pidx, r_meta_rd.used[RW-1:0]};
        w_rule_wdata = '{key: r_num, kind: r_act};
        w_rule_raddr = {w_pidx, r_idx};

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd    = t_cmd'(i_command);
                    n_pid    = i_profile_id;
                    n_num    = i_call_number;
                    n_act    = t_action'(i_rule_action);
                    n_status = 1'b0;
                    n_newp   = '0;
                    n_perm   = (t_cmd'(i_command) == CMD_CHECK);
                    n_hit    = 1'b0;
                    n_hact   = ACT_ALLOW;
                end
            end
            S_META: begin
                unique case (r_cmd)
                    CMD_CREATE: begin
                        if (w_prof_full) begin
                            n_status = 1'b1;
                        end else begin
                            w_meta_we    = 1'b1;
                            w_meta_waddr = r_prof_used[PW-1:0];
                            w_meta_wdata = '{active: 1'b0, used: '0};
                            n_newp       = NEWP_W'(r_prof_used);
                            n_prof_used  = r_prof_used + UW'(1);
                        end
                    end
                    CMD_ADD: begin
                        if (!w_pid_ok || w_rules_full) begin
                            n_status = 1'b1;
                        end else begin
                            w_rule_we         = 1'b1;
                            w_meta_we         = 1'b1;
                            w_meta_wdata.used = r_meta_rd.used + CW'(1);
                        end
                    end
                    CMD_ACTIVATE: begin
                        if (!w_pid_ok) begin
                            n_status = 1'b1;
                        end else begin
                            w_meta_we           = 1'b1;
                            w_meta_wdata.active = 1'b1;
                        end
                    end
                    CMD_CHECK: begin
                        // first rule read goes out now, data arrives in S_SCAN
                        n_cnt        = r_meta_rd.used;
                        n_idx        = '0;
                        w_rule_raddr = {w_pidx, RW'(0)};
                    end
                    default: n_status = r_status;
                endcase
            end
            S_SCAN: begin
                if (w_match) begin
                    n_hit  = 1'b1;
                    n_hact = w_rule_rd.kind;
                    unique case (w_rule_rd.kind)
                        ACT_ALLOW: n_allow = r_allow + COUNT_W'(1);
                        ACT_DENY, ACT_KILL: begin
                            n_viol = r_viol + COUNT_W'(1);
                            n_perm = 1'b0;
                        end
                        ACT_TRACE: n_perm = 1'b1;
                        default: n_perm = r_perm;
                    endcase
                end else begin
                    n_idx        = r_idx + RW'(1);
                    w_rule_raddr = {w_pidx, r_idx + RW'(1)};
                end
            end
            S_DONE: begin
                n_cnt = r_cnt;
            end
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prof_used <= '0;
            r_viol      <= '0;
            r_allow     <= '0;
        end else begin
            r_state     <= n_state;
            r_prof_used <= n_prof_used;
            r_viol      <= n_viol;
            r_allow     <= n_allow;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_pid    <= n_pid;
        r_num    <= n_num;
        r_act    <= n_act;
        r_status <= n_status;
        r_newp   <= n_newp;
        r_perm   <= n_perm;
        r_hit    <= n_hit;
        r_hact   <= n_hact;
        r_cnt    <= n_cnt;
        r_idx    <= n_idx;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status <= r_status;
            r_out_newp   <= r_newp;
            r_out_perm   <= r_perm;
            r_out_hit    <= r_hit;
            r_out_hact   <= r_hact;
            r_out_viol   <= r_viol;
            r_out_allow  <= r_allow;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_new_profile     = r_out_newp;
    assign o_permitted       = r_out_perm;
    assign o_rule_hit        = r_out_hit;
    assign o_hit_action      = r_out_hact;
    assign o_violation_count = r_out_viol;
    assign o_allowed_count   = r_out_allow;

endmodule

// ----- sv/srtf_checker.sv -----
// ----------------------------------------------------------------------------
// srtf_checker
// Port-level checks of the rule table filter, bound to the top level.
// ----------------------------------------------------------------------------
module srtf_checker
    import srtf_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input logic                o_status,
    input logic [NEWP_W-1:0]   o_new_profile,
    input logic                o_permitted,
    input logic                o_rule_hit,
    input logic [1:0]          o_hit_action
);

    // a result transaction stays up until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped before it was taken");

    // one command at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("command accepted while another is in flight");

    // a matched deny or kill rule refuses the call
    a_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rule_hit &&
        (o_hit_action == ACT_DENY || o_hit_action == ACT_KILL) |-> !o_permitted)
        else $error("deny or kill hit reported as permitted");

    // errors come only from create, add and activate
    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> !o_permitted && !o_rule_hit && o_new_profile == '0)
        else $error("error result carries check or create fields");

    // a created profile index never shows on a check result
    a_create_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_new_profile != '0 |-> !o_permitted && !o_rule_hit)
        else $error("new profile index on a check result");

endmodule

bind syscall_rule_table_filter srtf_checker u_srtf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_status      (o_status),
    .o_new_profile (o_new_profile),
    .o_permitted   (o_permitted),
    .o_rule_hit    (o_rule_hit),
    .o_hit_action  (o_hit_action)
);
